// ----- rtl/msd_pkg.sv -----
// Shared constants and types for the windowed mean squared displacement block.
`default_nettype none
package msd_pkg;

  localparam int DTMAX     = 32;
  localparam int ATOMS_MAX = 1024;
  localparam int SLOTS     = DTMAX - 1;
  localparam int LAG_W     = $clog2(DTMAX);
  localparam int ATOM_W    = $clog2(ATOMS_MAX);
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int POS_W     = 24;
  localparam int CFG_W     = 6;
  localparam int HIST_W    = 3 * POS_W;
  localparam int HIST_D    = SLOTS * ATOMS_MAX;
  localparam int SQ_W      = 2 * (POS_W + 1);
  localparam int DIST_W    = SQ_W + 2;
  localparam int SUM_W     = 64;
  localparam int CNT_W     = 32;
  localparam int MEAN_W    = 48;
  localparam int DRAIN_CYC = DTMAX + 8;
  localparam int DRAIN_W   = $clog2(DRAIN_CYC + 1);

  typedef struct packed {
    logic              vld;
    logic [LAG_W-1:0]  age;
    logic [DIST_W-1:0] dsq;
  } link_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_WAIT,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/msd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/msd_cell.sv -----
// One lag cell: holds the sum and count of one lag and passes the distance on.
`default_nettype none
module msd_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [msd_pkg::LAG_W-1:0]   idx,
  input  wire msd_pkg::link_t              link_in,
  output msd_pkg::link_t                   link_out,
  output logic      [msd_pkg::SUM_W-1:0]   sum,
  output logic      [msd_pkg::CNT_W-1:0]   count
);
  import msd_pkg::*;

  logic [SUM_W:0] sum_add;

  assign sum_add = {1'b0, sum} + {{(SUM_W + 1 - DIST_W){1'b0}}, link_in.dsq};

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.vld <= 1'b0;
      sum          <= '0;
      count        <= '0;
    end else begin
      link_out.vld <= link_in.vld;
      if (link_in.vld && link_in.age == idx && count != {CNT_W{1'b1}}) begin
        sum   <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        count <= count + 1'b1;
      end
    end
    link_out.age <= link_in.age;
    link_out.dsq <= link_in.dsq;
  end

endmodule
`default_nettype wire

// ----- rtl/msd_div.sv -----
// Restoring divider, one quotient bit per cycle, mean saturated to 48 bits.
`default_nettype none
module msd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [msd_pkg::SUM_W-1:0]   dividend,
  input  wire logic [msd_pkg::CNT_W-1:0]   divisor,
  output logic                             done,
  output logic      [msd_pkg::MEAN_W-1:0]  quotient
);
  import msd_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    rem;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;

  assign rem_sh  = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign quotient = (quo[SUM_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}} : quo[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!rem_sub[CNT_W]) begin
        rem <= rem_sub;
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/windowed_mean_squared_displacement.sv -----
// Top level: frame history, distance pipeline, lag cell chain and mean readout.
// Per atom: when selected, it is compared with each stored frame (up to 31).
// The compare rate is set by the single read port of the frame history RAM.
// On the last atom: chain drain, then per lag a division and an output that may stall.
// Reset (rst, synchronous) clears all sums, counts, ring pointers and sets lags to 32.
// History contents are not cleared; no clearing pass is run.
`default_nettype none
module windowed_mean_squared_displacement (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [msd_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [msd_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [msd_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [msd_pkg::POS_W-1:0] pos_z,
  input  wire logic                          selected,
  input  wire logic                          last_atom,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [msd_pkg::LAG_W-1:0]     lag,
  output logic      [msd_pkg::MEAN_W-1:0]    mean_sq_disp,
  output logic                               has_samples,
  output logic                               last_lag
);
  import msd_pkg::*;

  localparam int ADDR_W = $clog2(HIST_D);

  state_t state, state_next;

  logic [CFG_W-1:0]  lags_in_use;
  logic [CFG_W-1:0]  lags;
  logic [LAG_W-1:0]  window;
  logic [LAG_W-1:0]  used;
  logic [SLOT_W-1:0] oldest_slot;
  logic [SLOT_W-1:0] frames_stored;
  logic [ATOM_W-1:0] atom_counter;
  logic [ATOM_W-1:0] cur_atom;
  logic              cur_last;
  logic signed [POS_W-1:0] cur_x, cur_y, cur_z;
  logic [LAG_W-1:0]  rd_age;
  logic [LAG_W-1:0]  rd_used;
  logic [DRAIN_W-1:0] drain_cnt;
  logic [LAG_W-1:0]  out_age;
  logic              in_acc;
  logic              out_acc;

  logic [SLOT_W:0]   slot_raw;
  logic [SLOT_W-1:0] rd_slot;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [HIST_W-1:0] rdata;
  logic              rd_issue;
  logic              wr_now;
  logic              hist_we;

  logic              s1_vld, s2_vld;
  logic [LAG_W-1:0]  s1_age, s2_age;
  logic signed [POS_W:0] dx, dy, dz;
  logic [POS_W:0]    ax, ay, az;
  logic [SQ_W-1:0]   sqx, sqy, sqz;
  link_t             chain [DTMAX+1];

  logic [SUM_W-1:0]  cell_sum [DTMAX];
  logic [CNT_W-1:0]  cell_cnt [DTMAX];
  logic              div_start, div_done;
  logic [MEAN_W-1:0] div_q;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign lags = (lags_in_use < CFG_W'(2)) ? CFG_W'(2) :
                (lags_in_use > CFG_W'(DTMAX)) ? CFG_W'(DTMAX) : lags_in_use;
  assign window = LAG_W'(lags - 1'b1);
  assign used = ({1'b0, frames_stored} < window) ? LAG_W'(frames_stored) : window;

  assign slot_raw = {1'b0, oldest_slot} + (SLOT_W + 1)'(SLOTS) - (SLOT_W + 1)'(rd_age);
  assign rd_slot  = (slot_raw >= (SLOT_W + 1)'(SLOTS)) ?
                    SLOT_W'(slot_raw - (SLOT_W + 1)'(SLOTS)) : slot_raw[SLOT_W-1:0];
  assign raddr    = ADDR_W'({rd_slot, cur_atom});
  assign waddr    = ADDR_W'({oldest_slot, cur_atom});
  assign hist_we  = wr_now || (rd_issue && rd_age == rd_used);

  msd_ram #(.WIDTH(HIST_W), .DEPTH(HIST_D)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (waddr),
    .wdata ({cur_z, cur_y, cur_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (selected && used != '0) begin
            state_next = ST_READ;
          end else if (last_atom) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_READ: begin
        if (rd_age == rd_used) begin
          state_next = cur_last ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == DRAIN_W'(DRAIN_CYC)) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          state_next = last_lag ? ST_IDLE : ST_DIV;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    rd_issue  = (state == ST_READ);
    div_start = (state == ST_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      lags_in_use   <= CFG_W'(DTMAX);
      oldest_slot   <= '0;
      frames_stored <= '0;
      atom_counter  <= '0;
      drain_cnt     <= '0;
      out_age       <= '0;
      wr_now        <= 1'b0;
      s1_vld        <= 1'b0;
      s2_vld        <= 1'b0;
      chain[0].vld  <= 1'b0;
    end else begin
      state  <= state_next;
      wr_now <= in_acc && !(selected && used != '0);
      s1_vld <= rd_issue;
      s2_vld <= s1_vld;
      chain[0].vld <= s2_vld;
      if (cfg_wr_en) begin
        lags_in_use <= cfg_wr_data;
      end
      if (in_acc) begin
        atom_counter <= last_atom ? '0 :
                        (atom_counter == ATOM_W'(ATOMS_MAX - 1)) ? '0 : atom_counter + 1'b1;
      end
      drain_cnt <= (state == ST_DRAIN) ? drain_cnt + 1'b1 : '0;
      if (state == ST_DRAIN && state_next == ST_DIV) begin
        oldest_slot   <= (oldest_slot == SLOT_W'(SLOTS - 1)) ? '0 : oldest_slot + 1'b1;
        if (frames_stored != SLOT_W'(SLOTS)) begin
          frames_stored <= frames_stored + 1'b1;
        end
        out_age <= '0;
      end
      if (out_acc) begin
        out_age <= out_age + 1'b1;
      end
    end
    if (in_acc) begin
      cur_x    <= pos_x;
      cur_y    <= pos_y;
      cur_z    <= pos_z;
      cur_last <= last_atom;
      cur_atom <= atom_counter;
      rd_used  <= used;
      rd_age   <= LAG_W'(1);
    end else if (rd_issue) begin
      rd_age <= rd_age + 1'b1;
    end
    s1_age <= rd_age;
    s2_age <= s1_age;
    sqx    <= SQ_W'(ax * ax);
    sqy    <= SQ_W'(ay * ay);
    sqz    <= SQ_W'(az * az);
    chain[0].age <= s2_age;
    chain[0].dsq <= DIST_W'(sqx) + DIST_W'(sqy) + DIST_W'(sqz);
    if (div_done) begin
      lag          <= out_age;
      has_samples  <= (cell_cnt[out_age] != '0);
      mean_sq_disp <= (cell_cnt[out_age] != '0) ? div_q : '0;
      last_lag     <= ({1'b0, out_age} == CFG_W'(lags - 1'b1));
    end
  end

  assign dx = (POS_W + 1)'(cur_x) - (POS_W + 1)'($signed(rdata[POS_W-1:0]));
  assign dy = (POS_W + 1)'(cur_y) - (POS_W + 1)'($signed(rdata[2*POS_W-1:POS_W]));
  assign dz = (POS_W + 1)'(cur_z) - (POS_W + 1)'($signed(rdata[3*POS_W-1:2*POS_W]));
  assign ax = dx[POS_W] ? (POS_W + 1)'(-dx) : dx;
  assign ay = dy[POS_W] ? (POS_W + 1)'(-dy) : dy;
  assign az = dz[POS_W] ? (POS_W + 1)'(-dz) : dz;

  for (genvar i = 0; i < DTMAX; i++) begin : g_cell
    msd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (LAG_W'(i)),
      .link_in  (chain[i]),
      .link_out (chain[i+1]),
      .sum      (cell_sum[i]),
      .count    (cell_cnt[i])
    );
  end

  msd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cell_sum[out_age]),
    .divisor  (cell_cnt[out_age]),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
`default_nettype wire

// ----- rtl/msd_checker.sv -----
// Port-level checker for the mean squared displacement block, with its bind.
`default_nettype none
module msd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          last_atom,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [msd_pkg::LAG_W-1:0]     lag,
  input wire logic [msd_pkg::MEAN_W-1:0]    mean_sq_disp,
  input wire logic                          has_samples,
  input wire logic                          last_lag
);

  a_no_out_and_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item taken while results pending");

  a_lag0_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && lag == '0 |-> !has_samples && mean_sq_disp == '0)
    else $error("lag 0 reports samples");

  a_no_out_mid_frame: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last_atom |=> !out_valid)
    else $error("result without last atom");

  a_lag_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_lag |=> !out_valid)
    else $error("next lag shown without division");

  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_samples |-> mean_sq_disp == '0)
    else $error("mean nonzero with no samples");

endmodule

bind windowed_mean_squared_displacement msd_checker u_msd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last_atom    (last_atom),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .lag          (lag),
  .mean_sq_disp (mean_sq_disp),
  .has_samples  (has_samples),
  .last_lag     (last_lag)
);
`default_nettype wire
